### design/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types, codes and constant tables for the supported-rates element
// test-pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfs_pkg;

    // item field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 9;
    localparam int BYTE_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int STEP_W   = 5;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd3;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_EMPTY = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DUP   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_COUNT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_OVER  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MAX   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;

    // element constants
    localparam logic [BYTE_W-1:0] ELEM_ID    = 8'h01;
    localparam logic [BYTE_W-1:0] FILL_OVER  = 8'h96;
    localparam logic [BYTE_W-1:0] FILL_MAX   = 8'hFF;
    localparam logic [BYTE_W-1:0] NORMAL_LEN = 8'd7;
    localparam logic [BYTE_W-1:0] ROW_LEN    = 8'd8;

    // sequencer state
    typedef struct packed {
        logic                running;
        logic [PHASE_W-1:0]  phase;
        logic [STEP_W-1:0]   step;
    } seq_state_t;

    // steps allowed in each phase
    function automatic logic [STEP_W:0] step_limit(input logic [PHASE_W-1:0] ph);
        logic [STEP_W:0] lim;
        case (ph)
            PH_EMPTY: lim = 6'd2;
            PH_DUP:   lim = 6'd4;
            PH_COUNT: lim = 6'd32;
            PH_OVER:  lim = 6'd32;
            PH_MAX:   lim = 6'd1;
            default:  lim = 6'd0;
        endcase
        return lim;
    endfunction

    // normal seven-rate element
    function automatic logic [BYTE_W-1:0] normal_rate(input logic [2:0] k);
        logic [BYTE_W-1:0] v;
        case (k)
            3'd0:    v = 8'h96;
            3'd1:    v = 8'h18;
            3'd2:    v = 8'h24;
            3'd3:    v = 8'h30;
            3'd4:    v = 8'h48;
            3'd5:    v = 8'h60;
            3'd6:    v = 8'h6c;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // duplicate-rate rom, one row per step
    function automatic logic [BYTE_W-1:0] dup_rate(input logic [1:0] row,
                                                   input logic [2:0] col);
        logic [BYTE_W-1:0] v;
        case ({row, col})
            5'd0:  v = 8'h96;  5'd1:  v = 8'h96;  5'd2:  v = 8'h96;  5'd3:  v = 8'h30;
            5'd4:  v = 8'h30;  5'd5:  v = 8'h30;  5'd6:  v = 8'h30;  5'd7:  v = 8'h96;
            5'd8:  v = 8'h16;  5'd9:  v = 8'h16;  5'd10: v = 8'h16;  5'd11: v = 8'hB0;
            5'd12: v = 8'hB0;  5'd13: v = 8'hB0;  5'd14: v = 8'hB0;  5'd15: v = 8'h16;
            5'd16: v = 8'h02;  5'd17: v = 8'h82;  5'd18: v = 8'h02;  5'd19: v = 8'h30;
            5'd20: v = 8'hB0;  5'd21: v = 8'h30;  5'd22: v = 8'hB0;  5'd23: v = 8'h82;
            5'd24: v = 8'h00;  5'd25: v = 8'h00;  5'd26: v = 8'h80;  5'd27: v = 8'h80;
            5'd28: v = 8'hff;  5'd29: v = 8'h7f;  5'd30: v = 8'hff;  5'd31: v = 8'h7f;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/rfs_seq.sv
// ----------------------------------------------------------------------------
// rfs_seq
// Running flag, phase and step counter; applies start, advance and stop.
// ----------------------------------------------------------------------------
`default_nettype none

module rfs_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         item_en,
    input  wire logic [rfs_pkg::ACTION_W-1:0] action,
    output rfs_pkg::seq_state_t               state_next,
    output logic                              all_done
);
    import rfs_pkg::*;

    seq_state_t state_reg;

    // next state for the item in flight
    always_comb begin
        state_next = state_reg;
        all_done   = 1'b0;
        case (action)
            ACT_START: begin
                state_next.running = 1'b1;
                state_next.phase   = PH_EMPTY;
                state_next.step    = '0;
            end
            ACT_ADVANCE: begin
                if (state_reg.running) begin
                    if (state_reg.phase < PH_DONE &&
                        ({1'b0, state_reg.step} + 6'd1) < step_limit(state_reg.phase)) begin
                        state_next.step = state_reg.step + 5'd1;
                    end else begin
                        state_next.step  = '0;
                        state_next.phase = (state_reg.phase < PH_DONE) ?
                                           state_reg.phase + 3'd1 : PH_DONE;
                    end
                    if (state_next.phase >= PH_DONE) begin
                        state_next.running = 1'b0;
                        all_done           = 1'b1;
                    end
                end
            end
            ACT_STOP: begin
                state_next.running = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (item_en) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/rfs_elem.sv
// ----------------------------------------------------------------------------
// rfs_elem
// Shape of the current element and lookup of one element byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rfs_elem (
    input  wire rfs_pkg::seq_state_t          state,
    input  wire logic [rfs_pkg::ACTION_W-1:0] action,
    input  wire logic [rfs_pkg::INDEX_W-1:0]  byte_index,
    output logic [rfs_pkg::BYTE_W-1:0]        byte_value,
    output logic                              byte_valid,
    output logic                              element_present,
    output logic [rfs_pkg::BYTE_W-1:0]        data_length
);
    import rfs_pkg::*;

    logic                normal_mode;
    logic [INDEX_W-1:0]  over_len;
    logic [INDEX_W-1:0]  k;
    logic [BYTE_W-1:0]   data_byte;

    assign normal_mode = !state.running || (state.phase >= PH_DONE);
    assign over_len    = (state.step < 5'd16) ? (9'd8 + {4'b0, state.step})
                                              : (9'd271 - {4'b0, state.step});
    assign k           = byte_index - 9'd2;

    // element presence and length
    always_comb begin
        element_present = 1'b1;
        data_length     = NORMAL_LEN;
        if (!normal_mode) begin
            case (state.phase)
                PH_EMPTY: begin
                    data_length     = '0;
                    element_present = (state.step == '0);
                end
                PH_DUP, PH_COUNT: data_length = ROW_LEN;
                PH_OVER:          data_length = over_len[BYTE_W-1:0];
                default:          data_length = FILL_MAX;
            endcase
        end
    end

    // data byte at offset k
    always_comb begin
        if (normal_mode) begin
            data_byte = normal_rate(k[2:0]);
        end else begin
            case (state.phase)
                PH_DUP:   data_byte = dup_rate(state.step[1:0], k[2:0]);
                PH_COUNT: data_byte = {state.step, 3'b000} + k[BYTE_W-1:0];
                PH_OVER:  data_byte = FILL_OVER;
                PH_MAX:   data_byte = FILL_MAX;
                default:  data_byte = '0;
            endcase
        end
    end

    // read response
    always_comb begin
        byte_value = '0;
        byte_valid = 1'b0;
        if (action == ACT_READ && element_present) begin
            if (byte_index == 9'd0) begin
                byte_value = ELEM_ID;
                byte_valid = 1'b1;
            end else if (byte_index == 9'd1) begin
                byte_value = data_length;
                byte_valid = 1'b1;
            end else if (k < {1'b0, data_length}) begin
                byte_value = data_byte;
                byte_valid = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/rates_element_fuzz_sequencer_top.sv
// ----------------------------------------------------------------------------
// rates_element_fuzz_sequencer_top
// Supported-rates element test-pattern sequencer with stream ports.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns exactly one result item for
// each. An item passes an input register, then the sequencer update and the
// element byte lookup combinationally, then the result register, from which
// the result is shown. Throughput is one item a cycle as long as m_tready stays
// high; when the result register is held, the input register still takes one
// item behind it before s_tready drops.
`default_nettype none

module rates_element_fuzz_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // action[1:0], byte_index[10:2], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // byte_value[7:0], byte_valid[8],
                                        // element_present[9], data_length[17:10],
                                        // all_done[18], is_running[19],
                                        // phase_now[22:20], step_now[27:23], zero
);
    import rfs_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [ACTION_W-1:0] in_action_reg;
    logic [INDEX_W-1:0]  in_index_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic                advance;
    logic                s_accept;

    seq_state_t          state_next;
    logic                all_done;
    logic [BYTE_W-1:0]   byte_value;
    logic                byte_valid;
    logic                element_present;
    logic [BYTE_W-1:0]   data_length;

    // pipeline handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || advance;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tdata[1:0];
            in_index_reg  <= s_tdata[10:2];
        end
    end

    // sequencer state
    rfs_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (advance),
        .action     (in_action_reg),
        .state_next (state_next),
        .all_done   (all_done)
    );

    // element lookup on the updated state
    rfs_elem u_elem (
        .state           (state_next),
        .action          (in_action_reg),
        .byte_index      (in_index_reg),
        .byte_value      (byte_value),
        .byte_valid      (byte_valid),
        .element_present (element_present),
        .data_length     (data_length)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'b0000, state_next.step, state_next.phase,
                             state_next.running, all_done, data_length,
                             element_present, byte_valid, byte_value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### design/rfs_chk.sv
// ----------------------------------------------------------------------------
// rfs_chk
// Port-level checks on the result stream of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rfs_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // finishing the last phase leaves the sequencer stopped at phase 5
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> !m_tdata[19] && m_tdata[22:20] == 3'd5
                                    && m_tdata[27:23] == 5'd0)
        else $error("done without stopping at the final phase");

    // a valid byte needs a present element
    a_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[9])
        else $error("byte valid on an absent element");

    // an absent element has no data and is only seen while running in phase 0
    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[17:10] == 8'd0 && m_tdata[19]
                                     && m_tdata[22:20] == 3'd0)
        else $error("absent element outside phase 0 or with data");

    // while running the phase stays inside the schedule
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[22:20] < 3'd5)
        else $error("running with phase past the schedule");

endmodule

bind rates_element_fuzz_sequencer_top rfs_chk u_rfs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/tb_rates_element_fuzz_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_rates_element_fuzz_sequencer_top
// Self-checking bench for the supported-rates element test-pattern sequencer.
// Items go in from a queue through a clocked driver with random gaps. A clocked
// monitor takes results with random back-pressure and checks each one against
// a local model of the phase/step schedule and the element byte contents.
// ----------------------------------------------------------------------------
module tb_rates_element_fuzz_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int RANDOM_ITEMS   = 750;
    localparam int ADVANCES_PER_RUN = 71;   // 2 + 4 + 32 + 32 + 1

    // one input item
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  index;
    } seq_item_t;

    // one result item
    typedef struct {
        logic [BYTE_W-1:0]  byte_value;
        logic               byte_valid;
        logic               element_present;
        logic [BYTE_W-1:0]  data_length;
        logic               all_done;
        logic               is_running;
        logic [PHASE_W-1:0] phase_now;
        logic [STEP_W-1:0]  step_now;
    } elem_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // action[1:0], byte_index[10:2], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // byte_value[7:0], byte_valid[8],
                                    // element_present[9], data_length[17:10],
                                    // all_done[18], is_running[19],
                                    // phase_now[22:20], step_now[27:23], zero

    rates_element_fuzz_sequencer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    seq_item_t    pending_items[$];
    elem_result_t expected_results[$];
    seq_item_t    item_on_bus;

    int  mismatches   = 0;
    int  results_seen = 0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    bit  tx_taken     = 1'b0;
    int  hold_left    = 0;
    int  holds_made   = 0;
    int  next_hold_at = 200;
    int  idle_cycles  = 0;

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------
    logic               mdl_running = 1'b0;
    logic [PHASE_W-1:0] mdl_phase   = '0;
    logic [STEP_W-1:0]  mdl_step    = '0;

    int unsigned phase_steps[5] = '{2, 4, 32, 32, 1};
    logic [7:0]  normal_tbl[7]  = '{8'h96, 8'h18, 8'h24, 8'h30, 8'h48, 8'h60, 8'h6c};
    logic [7:0]  dup_tbl[4][8]  = '{
        '{8'h96, 8'h96, 8'h96, 8'h30, 8'h30, 8'h30, 8'h30, 8'h96},
        '{8'h16, 8'h16, 8'h16, 8'hB0, 8'hB0, 8'hB0, 8'hB0, 8'h16},
        '{8'h02, 8'h82, 8'h02, 8'h30, 8'hB0, 8'h30, 8'hB0, 8'h82},
        '{8'h00, 8'h00, 8'h80, 8'h80, 8'hff, 8'h7f, 8'hff, 8'h7f}
    };

    // data byte k of the element the model currently holds
    function automatic logic [7:0] element_byte(int unsigned k);
        logic [7:0] v;
        if (!mdl_running || mdl_phase >= PH_DONE) begin
            v = normal_tbl[k % 7];
        end else begin
            case (mdl_phase)
                PH_DUP:   v = dup_tbl[mdl_step[1:0]][k % 8];
                PH_COUNT: v = 8'((int'(mdl_step) * 8 + k) & 255);
                PH_OVER:  v = FILL_OVER;
                PH_MAX:   v = FILL_MAX;
                default:  v = 8'h00;
            endcase
        end
        return v;
    endfunction

    // apply one item to the model and return the result it should produce
    function automatic elem_result_t predict_element_read(seq_item_t it);
        elem_result_t r;
        int unsigned  len;
        int unsigned  idx;
        bit           present;
        r = '{default: '0};
        idx = it.index;
        case (it.action)
            ACT_START: begin
                mdl_running = 1'b1;
                mdl_phase   = PH_EMPTY;
                mdl_step    = '0;
            end
            ACT_ADVANCE: begin
                if (mdl_running) begin
                    if (mdl_phase < PH_DONE && int'(mdl_step) + 1 < phase_steps[mdl_phase]) begin
                        mdl_step = mdl_step + 1'b1;
                    end else begin
                        mdl_step  = '0;
                        mdl_phase = (mdl_phase < PH_DONE) ? mdl_phase + 1'b1 : PH_DONE;
                    end
                    if (mdl_phase >= PH_DONE) begin
                        mdl_running = 1'b0;
                        r.all_done  = 1'b1;
                    end
                end
            end
            ACT_STOP: mdl_running = 1'b0;
            default: ;
        endcase

        // shape of the element after the action
        present = 1'b1;
        if (!mdl_running || mdl_phase >= PH_DONE) begin
            len = 7;
        end else begin
            case (mdl_phase)
                PH_EMPTY: begin
                    len = 0;
                    present = (mdl_step == 0);
                end
                PH_DUP, PH_COUNT: len = 8;
                PH_OVER:  len = (mdl_step < 16) ? 8 + mdl_step : 271 - mdl_step;
                default:  len = 255;
            endcase
        end

        // byte lookup only for reads of a present element
        if (it.action == ACT_READ && present) begin
            if (idx == 0) begin
                r.byte_value = ELEM_ID;
                r.byte_valid = 1'b1;
            end else if (idx == 1) begin
                r.byte_value = 8'(len);
                r.byte_valid = 1'b1;
            end else if (idx - 2 < len) begin
                r.byte_value = element_byte(idx - 2);
                r.byte_valid = 1'b1;
            end
        end
        r.element_present = present;
        r.data_length     = 8'(len);
        r.is_running      = mdl_running;
        r.phase_now       = mdl_phase;
        r.step_now        = mdl_step;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [ACTION_W-1:0] act, int unsigned idx);
        seq_item_t it;
        it.action = act;
        it.index  = idx[INDEX_W-1:0];
        pending_items.push_back(it);
    endfunction

    // index mix: mostly near the start, some far out and near the 255-byte end
    function automatic int unsigned pick_index();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 10);
        else if (sel < 7)
            return $urandom_range(0, 40);
        else if (sel < 9)
            return $urandom_range(0, 256);
        else
            return $urandom_range(230, 256);
    endfunction

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: accept at rising edge, change at falling edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        tx_taken = aresetn && s_tvalid && s_tready;
        if (tx_taken)
            expected_results.push_back(predict_element_read(item_on_bus));
    end

    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !tx_taken)) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end else if (pending_items.size() != 0) begin
                item_on_bus = pending_items.pop_front();
                s_tdata  <= {5'b0, item_on_bus.index, item_on_bus.action};
                s_tvalid <= 1'b1;
                tx_gap   = draw_gap(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        elem_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            rx_gap = draw_gap(rx_calm);
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result %0h, nothing expected", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("byte_value",      want.byte_value,      m_tdata[7:0]);
                check_field("byte_valid",      want.byte_valid,      m_tdata[8]);
                check_field("element_present", want.element_present, m_tdata[9]);
                check_field("data_length",     want.data_length,     m_tdata[17:10]);
                check_field("all_done",        want.all_done,        m_tdata[18]);
                check_field("is_running",      want.is_running,      m_tdata[19]);
                check_field("phase_now",       want.phase_now,       m_tdata[22:20]);
                check_field("step_now",        want.step_now,        m_tdata[27:23]);
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (holds_made < 2 && results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            holds_made++;
            next_hold_at += 300;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int abort_at;
        int reads;
        int target;

        // directed: normal element while idle, edge indexes
        queue_item(ACT_READ, 0);
        queue_item(ACT_READ, 1);
        queue_item(ACT_READ, 8);        // last normal data byte
        queue_item(ACT_READ, 9);        // one past the end
        queue_item(ACT_READ, 255);
        queue_item(ACT_READ, 256);
        queue_item(ACT_ADVANCE, 0);     // advance while not running
        queue_item(ACT_STOP, 0);        // stop while stopped
        queue_item(ACT_START, 0);
        queue_item(ACT_READ, 1);        // empty element
        queue_item(ACT_READ, 2);
        queue_item(ACT_ADVANCE, 0);     // element absent
        queue_item(ACT_READ, 0);
        queue_item(ACT_ADVANCE, 0);     // first duplicate-rate row
        queue_item(ACT_READ, 2);
        queue_item(ACT_READ, 9);
        queue_item(ACT_READ, 10);
        queue_item(ACT_START, 0);       // restart while running
        queue_item(ACT_ADVANCE, 0);
        queue_item(ACT_STOP, 0);        // phase and step kept
        queue_item(ACT_READ, 1);
        queue_item(ACT_ADVANCE, 0);

        // random runs through the whole schedule, some cut short
        target = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < target) begin
            repeat ($urandom_range(0, 3))
                queue_item(ACTION_W'($urandom_range(0, 3)), pick_index());
            queue_item(ACT_START, pick_index());
            abort_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ADVANCES_PER_RUN) : 1000;
            for (int a = 0; a < ADVANCES_PER_RUN; a++) begin
                if (a == abort_at) begin
                    queue_item($urandom_range(0, 1) ? ACT_STOP : ACT_START, pick_index());
                    break;
                end
                reads = $urandom_range(0, 3);
                repeat (reads)
                    queue_item(ACT_READ, pick_index());
                queue_item(ACT_ADVANCE, pick_index());
            end
            repeat ($urandom_range(0, 3))
                queue_item(ACT_READ, pick_index());
        end

        // the last run may overshoot, cut it back to the target count
        while (pending_items.size() > target)
            void'(pending_items.pop_back());

        // reset
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // drain
        while (pending_items.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
